// ===== rtl/srht_pkg.sv =====
`default_nettype none

package srht_pkg;

    // Width of the register index on the configuration channel.
    localparam int CFG_IDX_BITS = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RECT_X_A = 8'd0,
        CFG_RECT_Y_A = 8'd1,
        CFG_RECT_X_B = 8'd2,
        CFG_RECT_Y_B = 8'd3
    } t_cfg_idx;

    // Per-edge qualification: the segment spans the edge's line and the edge is usable.
    typedef struct packed {
        logic bottom;
        logic right;
        logic top;
        logic left;
    } t_edge_ok;

endpackage

`default_nettype wire

// ===== rtl/srht_if.sv =====
`default_nettype none

// Segment request channel.
interface srht_seg_if #(
    parameter int COORD_BITS = 24
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

// Hit result channel.
interface srht_hit_if ();
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, output hit, input ready);
    modport sink (input valid, input hit, output ready);
endinterface

// Configuration write channel.
interface srht_cfg_if #(
    parameter int COORD_BITS = 24
) ();
    import srht_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [COORD_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/segment_rect_hit_test_top.sv =====
// Segment versus viewport rectangle hit test.
// Requests arrive on i_seg as two endpoints (start, end) in signed Q16.8 and
// each one produces exactly one request on o_res carrying a single hit bit.
// The rectangle is set through i_cfg, a write channel of register index and
// data: 0 rect_x_a, 1 rect_y_a, 2 rect_x_b, 3 rect_y_b. Other indexes are
// ignored, and i_cfg is always ready. Write only while no segment is in
// flight; the normalized bounds are registered behind the raw registers.
// Datapath: input register, then one combinational pass (differences,
// endpoint tests, four cross products and the edge compares) into the
// result register. A segment passes the input and then the result register;
// one segment per cycle is taken while o_res does not stall.
// Each register loads whenever it is empty or the one after it moves, so
// i_seg stays ready while a stalled result waits, until both registers
// are full. A stall on o_res holds the result and its valid unchanged.
// Reset clears the rectangle to all zeros and empties both registers.
`default_nettype none

module segment_rect_hit_test_top #(
    parameter int COORD_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    srht_seg_if.sink     i_seg,
    srht_cfg_if.sink     i_cfg,
    srht_hit_if.source   o_res
);
    import srht_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    // Register valids and load enables.
    logic r_v0;
    logic r_v1;
    logic w_en0;
    logic w_en1;

    logic signed [COORD_BITS-1:0] r_x0;
    logic signed [COORD_BITS-1:0] r_y0;
    logic signed [COORD_BITS-1:0] r_x1;
    logic signed [COORD_BITS-1:0] r_y1;

    logic signed [COORD_BITS-1:0] w_xmin;
    logic signed [COORD_BITS-1:0] w_xmax;
    logic signed [COORD_BITS-1:0] w_ymin;
    logic signed [COORD_BITS-1:0] w_ymax;
    logic                         w_xdeg;
    logic                         w_ydeg;

    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;
    logic signed [DW-1:0] w_axn;
    logic signed [DW-1:0] w_axx;
    logic signed [DW-1:0] w_ayn;
    logic signed [DW-1:0] w_ayx;
    logic                 w_inside;

    logic signed [PW-1:0] w_pa;
    logic signed [PW-1:0] w_pb;
    logic signed [PW-1:0] w_pc;
    logic signed [PW-1:0] w_pd;
    logic                 w_dx_neg;
    logic                 w_dy_neg;
    t_edge_ok             w_ok;

    // Elastic control of the input and result registers.
    assign w_en1 = !r_v1 || o_res.ready;
    assign w_en0 = !r_v0 || w_en1;

    assign i_seg.ready = w_en0;
    assign o_res.valid = r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (w_en0) begin
                r_v0 <= i_seg.valid;
            end
            if (w_en1) begin
                r_v1 <= r_v0;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            r_x0 <= i_seg.start_x;
            r_y0 <= i_seg.start_y;
            r_x1 <= i_seg.end_x;
            r_y1 <= i_seg.end_y;
        end
    end

    srht_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_xmin  (w_xmin),
        .o_xmax  (w_xmax),
        .o_ymin  (w_ymin),
        .o_ymax  (w_ymax),
        .o_xdeg  (w_xdeg),
        .o_ydeg  (w_ydeg)
    );

    srht_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_x0     (r_x0),
        .i_y0     (r_y0),
        .i_x1     (r_x1),
        .i_y1     (r_y1),
        .i_xmin   (w_xmin),
        .i_xmax   (w_xmax),
        .i_ymin   (w_ymin),
        .i_ymax   (w_ymax),
        .o_dx     (w_dx),
        .o_dy     (w_dy),
        .o_axn    (w_axn),
        .o_axx    (w_axx),
        .o_ayn    (w_ayn),
        .o_ayx    (w_ayx),
        .o_inside (w_inside)
    );

    srht_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .i_dx     (w_dx),
        .i_dy     (w_dy),
        .i_axn    (w_axn),
        .i_axx    (w_axx),
        .i_ayn    (w_ayn),
        .i_ayx    (w_ayx),
        .i_xdeg   (w_xdeg),
        .i_ydeg   (w_ydeg),
        .o_pa     (w_pa),
        .o_pb     (w_pb),
        .o_pc     (w_pc),
        .o_pd     (w_pd),
        .o_dx_neg (w_dx_neg),
        .o_dy_neg (w_dy_neg),
        .o_ok     (w_ok)
    );

    srht_decide #(
        .COORD_BITS (COORD_BITS)
    ) u_decide (
        .i_clk    (i_clk),
        .i_en     (w_en1),
        .i_pa     (w_pa),
        .i_pb     (w_pb),
        .i_pc     (w_pc),
        .i_pd     (w_pd),
        .i_dx_neg (w_dx_neg),
        .i_dy_neg (w_dy_neg),
        .i_ok     (w_ok),
        .i_inside (w_inside),
        .o_hit    (o_res.hit)
    );

    // An empty input register must never refuse a segment.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v0 |-> i_seg.ready)
        else $error("segment channel not ready with an empty input register");

    // An accepted segment lands in the input register.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_seg.valid && i_seg.ready) |=> r_v0)
        else $error("accepted segment was lost");

    // A held segment moves into the result register when it is free.
    a_result_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v0 && (!r_v1 || o_res.ready)) |=> o_res.valid)
        else $error("result did not reach the output register");

endmodule

`default_nettype wire

// ===== rtl/srht_cfg.sv =====
`default_nettype none

module srht_cfg #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    srht_cfg_if.sink                     i_cfg,
    output logic signed [COORD_BITS-1:0] o_xmin,
    output logic signed [COORD_BITS-1:0] o_xmax,
    output logic signed [COORD_BITS-1:0] o_ymin,
    output logic signed [COORD_BITS-1:0] o_ymax,
    output logic                         o_xdeg,
    output logic                         o_ydeg
);
    import srht_pkg::*;

    logic signed [COORD_BITS-1:0] r_x_a;
    logic signed [COORD_BITS-1:0] r_y_a;
    logic signed [COORD_BITS-1:0] r_x_b;
    logic signed [COORD_BITS-1:0] r_y_b;
    logic signed [COORD_BITS-1:0] r_xmin;
    logic signed [COORD_BITS-1:0] r_xmax;
    logic signed [COORD_BITS-1:0] r_ymin;
    logic signed [COORD_BITS-1:0] r_ymax;
    logic                         r_xdeg;
    logic                         r_ydeg;
    logic                         n_x_lt;
    logic                         n_y_lt;

    // Writes are always taken; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_a <= '0;
            r_y_a <= '0;
            r_x_b <= '0;
            r_y_b <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_RECT_X_A: r_x_a <= i_cfg.data;
                CFG_RECT_Y_A: r_y_a <= i_cfg.data;
                CFG_RECT_X_B: r_x_b <= i_cfg.data;
                CFG_RECT_Y_B: r_y_b <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Normalized bounds, registered behind the raw registers.
    assign n_x_lt = (r_x_a < r_x_b);
    assign n_y_lt = (r_y_a < r_y_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xmin <= '0;
            r_xmax <= '0;
            r_ymin <= '0;
            r_ymax <= '0;
            r_xdeg <= 1'b1;
            r_ydeg <= 1'b1;
        end else begin
            r_xmin <= n_x_lt ? r_x_a : r_x_b;
            r_xmax <= n_x_lt ? r_x_b : r_x_a;
            r_ymin <= n_y_lt ? r_y_a : r_y_b;
            r_ymax <= n_y_lt ? r_y_b : r_y_a;
            r_xdeg <= (r_x_a == r_x_b);
            r_ydeg <= (r_y_a == r_y_b);
        end
    end

    assign o_xmin = r_xmin;
    assign o_xmax = r_xmax;
    assign o_ymin = r_ymin;
    assign o_ymax = r_ymax;
    assign o_xdeg = r_xdeg;
    assign o_ydeg = r_ydeg;

endmodule

`default_nettype wire

// ===== rtl/srht_setup.sv =====
`default_nettype none

module srht_setup #(
    parameter int COORD_BITS = 24
) (
    input  logic signed [COORD_BITS-1:0] i_x0,
    input  logic signed [COORD_BITS-1:0] i_y0,
    input  logic signed [COORD_BITS-1:0] i_x1,
    input  logic signed [COORD_BITS-1:0] i_y1,
    input  logic signed [COORD_BITS-1:0] i_xmin,
    input  logic signed [COORD_BITS-1:0] i_xmax,
    input  logic signed [COORD_BITS-1:0] i_ymin,
    input  logic signed [COORD_BITS-1:0] i_ymax,
    output logic signed [COORD_BITS:0]   o_dx,
    output logic signed [COORD_BITS:0]   o_dy,
    output logic signed [COORD_BITS:0]   o_axn,
    output logic signed [COORD_BITS:0]   o_axx,
    output logic signed [COORD_BITS:0]   o_ayn,
    output logic signed [COORD_BITS:0]   o_ayx,
    output logic                         o_inside
);
    localparam int DW = COORD_BITS + 1;

    logic n_in0;
    logic n_in1;

    // Endpoint containment, edges included.
    assign n_in0 = (i_x0 >= i_xmin) && (i_x0 <= i_xmax) &&
                   (i_y0 >= i_ymin) && (i_y0 <= i_ymax);
    assign n_in1 = (i_x1 >= i_xmin) && (i_x1 <= i_xmax) &&
                   (i_y1 >= i_ymin) && (i_y1 <= i_ymax);

    // Segment direction and rectangle bounds relative to the start point.
    assign o_dx     = DW'(i_x1) - DW'(i_x0);
    assign o_dy     = DW'(i_y1) - DW'(i_y0);
    assign o_axn    = DW'(i_xmin) - DW'(i_x0);
    assign o_axx    = DW'(i_xmax) - DW'(i_x0);
    assign o_ayn    = DW'(i_ymin) - DW'(i_y0);
    assign o_ayx    = DW'(i_ymax) - DW'(i_y0);
    assign o_inside = n_in0 | n_in1;

endmodule

`default_nettype wire

// ===== rtl/srht_mul.sv =====
`default_nettype none

module srht_mul #(
    parameter int COORD_BITS = 24
) (
    input  logic signed [COORD_BITS:0]     i_dx,
    input  logic signed [COORD_BITS:0]     i_dy,
    input  logic signed [COORD_BITS:0]     i_axn,
    input  logic signed [COORD_BITS:0]     i_axx,
    input  logic signed [COORD_BITS:0]     i_ayn,
    input  logic signed [COORD_BITS:0]     i_ayx,
    input  logic                           i_xdeg,
    input  logic                           i_ydeg,
    output logic signed [2*COORD_BITS+1:0] o_pa,
    output logic signed [2*COORD_BITS+1:0] o_pb,
    output logic signed [2*COORD_BITS+1:0] o_pc,
    output logic signed [2*COORD_BITS+1:0] o_pd,
    output logic                           o_dx_neg,
    output logic                           o_dy_neg,
    output srht_pkg::t_edge_ok             o_ok
);
    import srht_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    // True when the edge line lies between the segment's endpoints, i.e. the
    // offset n sits in [0, d] for d > 0 or in [d, 0] for d < 0.
    function automatic logic f_span(input logic signed [DW-1:0] n,
                                    input logic signed [DW-1:0] d);
        logic r;
        if (d[DW-1]) begin
            r = (n <= 0) && (n >= d);
        end else begin
            r = (n >= 0) && (n <= d);
        end
        return r;
    endfunction

    // A parallel or zero-length edge never counts as crossed.
    always_comb begin
        o_ok.bottom = (i_dy != '0) && !i_xdeg && f_span(i_ayn, i_dy);
        o_ok.top    = (i_dy != '0) && !i_xdeg && f_span(i_ayx, i_dy);
        o_ok.right  = (i_dx != '0) && !i_ydeg && f_span(i_axx, i_dx);
        o_ok.left   = (i_dx != '0) && !i_ydeg && f_span(i_axn, i_dx);
    end

    // The four cross products, each shared by three of the edges.
    assign o_pa     = PW'(i_axn) * PW'(i_dy);
    assign o_pb     = PW'(i_axx) * PW'(i_dy);
    assign o_pc     = PW'(i_ayn) * PW'(i_dx);
    assign o_pd     = PW'(i_ayx) * PW'(i_dx);
    assign o_dx_neg = i_dx[DW-1];
    assign o_dy_neg = i_dy[DW-1];

endmodule

`default_nettype wire

// ===== rtl/srht_decide.sv =====
`default_nettype none

module srht_decide #(
    parameter int COORD_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [2*COORD_BITS+1:0] i_pa,
    input  logic signed [2*COORD_BITS+1:0] i_pb,
    input  logic signed [2*COORD_BITS+1:0] i_pc,
    input  logic signed [2*COORD_BITS+1:0] i_pd,
    input  logic                           i_dx_neg,
    input  logic                           i_dy_neg,
    input  srht_pkg::t_edge_ok             i_ok,
    input  logic                           i_inside,
    output logic                           o_hit
);
    import srht_pkg::*;

    localparam int PW = 2 * (COORD_BITS + 1);

    logic r_hit;
    logic n_bottom;
    logic n_top;
    logic n_right;
    logic n_left;

    // Crossing point inside the edge: the segment product lies between the
    // edge-end products, with the order flipped for a negative direction.
    function automatic logic f_between(input logic signed [PW-1:0] lo,
                                       input logic signed [PW-1:0] n,
                                       input logic signed [PW-1:0] hi,
                                       input logic                 neg);
        logic r;
        if (neg) begin
            r = (hi <= n) && (n <= lo);
        end else begin
            r = (lo <= n) && (n <= hi);
        end
        return r;
    endfunction

    assign n_bottom = i_ok.bottom && f_between(i_pa, i_pc, i_pb, i_dy_neg);
    assign n_top    = i_ok.top    && f_between(i_pa, i_pd, i_pb, i_dy_neg);
    assign n_right  = i_ok.right  && f_between(i_pc, i_pb, i_pd, i_dx_neg);
    assign n_left   = i_ok.left   && f_between(i_pc, i_pa, i_pd, i_dx_neg);

    // Result register; it holds while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= i_inside | n_bottom | n_top | n_right | n_left;
        end
    end

    assign o_hit = r_hit;

endmodule

`default_nettype wire

// ===== verif/segment_rect_hit_test_top_tb.sv =====
`timescale 1ns / 1ps

module segment_rect_hit_test_top_tb;
    import srht_pkg::*;

    localparam int  COORD_BITS     = 24;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  ITEMS_PER_HALF = 100;
    localparam longint COORD_MAX   = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN   = -(64'sd1 <<< (COORD_BITS - 1));

    // Indexes outside the register map; writes there must leave the rectangle alone.
    localparam logic [CFG_IDX_BITS-1:0] IDX_UNMAPPED_LOW = 8'd4;
    localparam logic [CFG_IDX_BITS-1:0] IDX_UNMAPPED_TOP = 8'hFF;

    // Rectangle shapes used by the random phases.
    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_FULL,
        SHAPE_THIN_X,
        SHAPE_THIN_Y,
        SHAPE_POINT
    } t_rect_shape;

    typedef struct {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
    } t_segment;

    logic i_clk = 1'b0;
    logic i_rst_n;

    srht_seg_if #(.COORD_BITS(COORD_BITS)) seg_ch ();
    srht_cfg_if #(.COORD_BITS(COORD_BITS)) cfg_ch ();
    srht_hit_if                            res_ch ();

    segment_rect_hit_test_top #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // Local copy of the viewport registers, updated on every accepted write.
    logic [COORD_BITS-1:0] rect_x_a = '0;
    logic [COORD_BITS-1:0] rect_y_a = '0;
    logic [COORD_BITS-1:0] rect_x_b = '0;
    logic [COORD_BITS-1:0] rect_y_b = '0;

    t_segment pending_segments[$];
    logic     hit_expected[$];
    t_segment drive_seg;
    logic     want_hit;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatch_count = 0;
    int segments_sent  = 0;
    int hits_seen      = 0;
    int reg_writes     = 0;
    int idle_cycles    = 0;

    t_rect_shape phase_shape[8] = '{SHAPE_RANDOM, SHAPE_FULL, SHAPE_THIN_X, SHAPE_RANDOM,
                                    SHAPE_THIN_Y, SHAPE_RANDOM, SHAPE_POINT, SHAPE_RANDOM};

    // Does the segment cross the bound v = k between lo and hi (both ends included)?
    // Vertical bounds reuse this with the axes swapped.
    function automatic logic spans_bound(longint u0, longint v0, longint u1, longint v1,
                                         longint k, longint lo, longint hi);
        longint du;
        longint dv;
        longint n;
        du = u1 - u0;
        dv = v1 - v0;
        n  = k - v0;
        // A bound parallel to the segment, or one of zero length, never counts.
        if (dv == 0 || lo == hi) return 1'b0;
        if (dv < 0) begin
            dv = -dv;
            n  = -n;
        end
        if (n < 0 || n > dv) return 1'b0;
        return ((lo - u0) * dv <= n * du) && (n * du <= (hi - u0) * dv);
    endfunction

    function automatic logic predict_hit(t_segment s);
        longint xa, xb, ya, yb;
        longint xlo, xhi, ylo, yhi;
        longint x0, y0, x1, y1;
        xa = $signed(rect_x_a);
        xb = $signed(rect_x_b);
        ya = $signed(rect_y_a);
        yb = $signed(rect_y_b);
        xlo = (xa < xb) ? xa : xb;
        xhi = (xa < xb) ? xb : xa;
        ylo = (ya < yb) ? ya : yb;
        yhi = (ya < yb) ? yb : ya;
        x0 = $signed(s.sx);
        y0 = $signed(s.sy);
        x1 = $signed(s.ex);
        y1 = $signed(s.ey);
        return (x0 >= xlo && x0 <= xhi && y0 >= ylo && y0 <= yhi)
            || (x1 >= xlo && x1 <= xhi && y1 >= ylo && y1 <= yhi)
            || spans_bound(x0, y0, x1, y1, ylo, xlo, xhi)
            || spans_bound(y0, x0, y1, x1, xhi, ylo, yhi)
            || spans_bound(x0, y0, x1, y1, yhi, xlo, xhi)
            || spans_bound(y0, x0, y1, x1, xlo, ylo, yhi);
    endfunction

    // Segment driver: pulls the next pending request when the channel is free.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_ch.valid <= 1'b0;
        end else if (!seg_ch.valid || seg_ch.ready) begin
            if (pending_segments.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drive_seg = pending_segments.pop_front();
                seg_ch.start_x <= drive_seg.sx;
                seg_ch.start_y <= drive_seg.sy;
                seg_ch.end_x   <= drive_seg.ex;
                seg_ch.end_y   <= drive_seg.ey;
                seg_ch.valid   <= 1'b1;
            end else begin
                seg_ch.valid <= 1'b0;
            end
        end
    end

    // Predict the hit bit for every accepted segment request.
    always @(posedge i_clk) begin
        if (i_rst_n && seg_ch.valid && seg_ch.ready) begin
            hit_expected.push_back(predict_hit('{seg_ch.start_x, seg_ch.start_y,
                                                 seg_ch.end_x, seg_ch.end_y}));
            segments_sent++;
        end
    end

    // Result monitor with random backpressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b1;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            if (res_ch.valid && res_ch.ready) begin
                if (hit_expected.size() == 0) begin
                    $display("%0t: result with none expected, expected none, actual hit=%0b",
                             $time, res_ch.hit);
                    mismatch_count++;
                end else begin
                    want_hit = hit_expected.pop_front();
                    if (res_ch.hit !== want_hit) begin
                        $display("%0t: hit mismatch, expected %0b, actual %0b",
                                 $time, want_hit, res_ch.hit);
                        mismatch_count++;
                    end
                    if (res_ch.hit === 1'b1) hits_seen++;
                end
            end
        end
    end

    // Watchdog: give up when no channel has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (seg_ch.valid && seg_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic add_segment(longint x0, longint y0, longint x1, longint y1);
        pending_segments.push_back('{COORD_BITS'(x0), COORD_BITS'(y0),
                                     COORD_BITS'(x1), COORD_BITS'(y1)});
    endtask

    // Write one register and mirror it into the local copy once accepted.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, longint value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= COORD_BITS'(value);
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_RECT_X_A: rect_x_a = COORD_BITS'(value);
            CFG_RECT_Y_A: rect_y_a = COORD_BITS'(value);
            CFG_RECT_X_B: rect_x_b = COORD_BITS'(value);
            CFG_RECT_Y_B: rect_y_b = COORD_BITS'(value);
            default: ;
        endcase
    endtask

    // Wait until nothing is queued, nothing is on the wire and no result is owed.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_segments.size() != 0 || seg_ch.valid || hit_expected.size() != 0);
    endtask

    // Pick a new rectangle; a and b are swapped at random so both orders are seen.
    task automatic set_rect(t_rect_shape shape);
        longint cx, cy, hx, hy;
        cx = longint'($urandom_range(0, 1 << (COORD_BITS - 1))) - (1 << (COORD_BITS - 2));
        cy = longint'($urandom_range(0, 1 << (COORD_BITS - 1))) - (1 << (COORD_BITS - 2));
        hx = $urandom_range(0, 1 << $urandom_range(2, 20));
        hy = $urandom_range(0, 1 << $urandom_range(2, 20));
        if (shape == SHAPE_THIN_X || shape == SHAPE_POINT) hx = 0;
        if (shape == SHAPE_THIN_Y || shape == SHAPE_POINT) hy = 0;
        if (shape == SHAPE_FULL) begin
            write_reg(CFG_RECT_X_A, COORD_MAX);
            write_reg(CFG_RECT_Y_A, COORD_MAX);
            write_reg(CFG_RECT_X_B, COORD_MIN);
            write_reg(CFG_RECT_Y_B, COORD_MIN);
        end else if ($urandom_range(0, 1)) begin
            write_reg(CFG_RECT_X_A, cx - hx);
            write_reg(CFG_RECT_Y_A, cy + hy);
            write_reg(CFG_RECT_X_B, cx + hx);
            write_reg(CFG_RECT_Y_B, cy - hy);
        end else begin
            write_reg(CFG_RECT_Y_B, cy + hy);
            write_reg(CFG_RECT_X_B, cx - hx);
            write_reg(CFG_RECT_Y_A, cy - hy);
            write_reg(CFG_RECT_X_A, cx + hx);
        end
    endtask

    // A coordinate on, just beside, or somewhere around the span [lo, hi].
    function automatic longint near_coord(longint lo, longint hi);
        longint w;
        w = hi - lo + 1;
        if (w < 64) w = 64;
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            2: return lo - $urandom_range(1, 16);
            3: return hi + $urandom_range(1, 16);
            default: return lo - w + (longint'($urandom) % (3 * w + 1));
        endcase
    endfunction

    // Random segments shaped around the current rectangle, with some pure noise.
    task automatic add_random_segments(int count);
        longint xlo, xhi, ylo, yhi;
        longint x0, y0, x1, y1;
        int     pick;
        xlo = ($signed(rect_x_a) < $signed(rect_x_b)) ? $signed(rect_x_a) : $signed(rect_x_b);
        xhi = ($signed(rect_x_a) < $signed(rect_x_b)) ? $signed(rect_x_b) : $signed(rect_x_a);
        ylo = ($signed(rect_y_a) < $signed(rect_y_b)) ? $signed(rect_y_a) : $signed(rect_y_b);
        yhi = ($signed(rect_y_a) < $signed(rect_y_b)) ? $signed(rect_y_b) : $signed(rect_y_a);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            x0 = near_coord(xlo, xhi);
            y0 = near_coord(ylo, yhi);
            x1 = near_coord(xlo, xhi);
            y1 = near_coord(ylo, yhi);
            if (pick < 10) begin
                // Full-range noise so every input bit toggles.
                x0 = $urandom;
                y0 = $urandom;
                x1 = $urandom;
                y1 = $urandom;
            end else if (pick < 15) begin
                // Zero-length segment.
                x1 = x0;
                y1 = y0;
            end else if (pick < 25) begin
                // Axis-parallel segment, often lying on a bound.
                if ($urandom_range(0, 1)) y1 = y0;
                else x1 = x0;
            end else if (pick < 40) begin
                // Start point drawn from inside the rectangle, edges included.
                x0 = xlo + (longint'($urandom) % (xhi - xlo + 1));
                y0 = ylo + (longint'($urandom) % (yhi - ylo + 1));
            end
            add_segment(x0, y0, x1, y1);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        seg_ch.valid   = 1'b0;
        seg_ch.start_x = '0;
        seg_ch.start_y = '0;
        seg_ch.end_x   = '0;
        seg_ch.end_y   = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        res_ch.ready   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset rectangle is a single point at the origin: every bound has zero length.
        @(negedge i_clk);
        add_segment(0, 0, 0, 0);
        add_segment(-100, -100, 100, 100);
        add_segment(0, 0, 50, 7);
        add_segment(1, 0, 1, 0);
        wait_drained();

        // Directed rectangle given with both pairs inverted: x in [-2560, 5120],
        // y in [-1280, 3840].
        write_reg(CFG_RECT_X_A, 5120);
        write_reg(CFG_RECT_Y_A, 3840);
        write_reg(CFG_RECT_X_B, -2560);
        write_reg(CFG_RECT_Y_B, -1280);
        @(negedge i_clk);
        add_segment(0, 0, 100, 100);
        add_segment(-2560, -1280, -9000, -9000);
        add_segment(5120, 3840, 9000, 9000);
        add_segment(-2561, 0, -9000, 0);
        add_segment(-9000, 1000, 9000, 1000);
        add_segment(9000, 1000, -9000, 1000);
        add_segment(1000, -9000, 1000, 9000);
        // Segments lying along the top bound, one overlapping and one short of it.
        add_segment(-9000, 3840, 9000, 3840);
        add_segment(-9000, 3840, -2561, 3840);
        // Diagonal through a corner exactly, and one that just misses it.
        add_segment(-3560, -280, -1560, -2280);
        add_segment(-3561, -280, -1561, -2280);
        add_segment(10, 10, 10, 10);
        add_segment(9000, 9000, 9000, 9000);
        add_segment(5120, 0, 5120, 0);
        add_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        add_segment(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN);
        add_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        add_segment(5120, 1000, 9000, 1000);
        add_segment(5121, 1000, 9000, 1000);
        add_segment(4000, 5000, 6000, 3000);
        wait_drained();

        // Writes to unmapped indexes must not disturb the rectangle.
        write_reg(IDX_UNMAPPED_LOW, 0);
        write_reg(IDX_UNMAPPED_TOP, COORD_MAX);
        @(negedge i_clk);
        add_segment(-2560, -1280, -2560, -1280);
        add_segment(-2561, -1281, -2561, -1281);
        wait_drained();

        // Random phases: each one gets a rectangle and a handshake profile, and the
        // sender holds off halfway until every result is back.
        for (int phase = 0; phase < 8; phase++) begin
            set_rect(phase_shape[phase]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            @(negedge i_clk);
            add_random_segments(ITEMS_PER_HALF);
            wait_drained();
            add_random_segments(ITEMS_PER_HALF);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        $display("Checked %0d segment requests (%0d hits) against %0d register writes,",
                 segments_sent, hits_seen, reg_writes);
        $display("covering degenerate, full-range and random rectangles under four stall mixes.");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
